// ===== hdl/mi3_pkg.sv =====
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EL_W      = 32;
  localparam int N_EL      = 9;
  localparam int N_DET     = 3;
  localparam int PROD_W    = 2 * EL_W;
  localparam int COF_W     = PROD_W + 1;
  localparam int DET_W     = COF_W + EL_W + 1;
  localparam int REM_W     = PROD_W + 2 * FRAC_BITS;
  localparam int Q_W       = EL_W;
  localparam int STEPS     = Q_W;
  localparam int CMP_W     = ((REM_W > DET_W + STEPS - 1) ? REM_W : DET_W + STEPS - 1) + 1;

  // element index = column*3 + row; cofactor c = pos_a*pos_b - neg_a*neg_b
  localparam int CP_A [N_EL] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CP_B [N_EL] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CN_A [N_EL] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int CN_B [N_EL] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  // first-row expansion: elements of row 0 times cofactors 0..2
  localparam int DET_EL [N_DET] = '{0, 3, 6};

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             neg;
  } lane_res_t;

  // round to nearest (ties away), apply sign, saturate to EL_W bits
  function automatic logic [EL_W-1:0] round_sat(input logic [REM_W-1:0] rem,
                                                 input logic [DET_W-1:0] den,
                                                 input logic [Q_W-1:0]   quo,
                                                 input logic             neg);
    logic [CMP_W-1:0] r2;
    logic [CMP_W-1:0] dd;
    logic             rnd;
    logic [Q_W:0]     qq;
    logic [EL_W-1:0]  res;
    r2  = CMP_W'(rem) << 1;
    dd  = CMP_W'(den);
    rnd = (r2 >= dd);
    qq  = {1'b0, quo} + (Q_W+1)'(rnd);
    if (quo[Q_W-1] || qq[Q_W-1]) begin
      res = neg ? {1'b1, {(EL_W-1){1'b0}}} : {1'b0, {(EL_W-1){1'b1}}};
    end else if (neg) begin
      res = ~qq[Q_W-1:0] + 1'b1;
    end else begin
      res = qq[Q_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/matrix3_inverse.sv =====
// matrix3_inverse: inverse of one 3x3 Q16.16 matrix per item
// input channel: in_valid / in_stall, nine elements a_cCrR in column-major order
// output channel: out_valid / out_stall, nine elements inv_cCrR plus singular
// an item is taken at a clock edge where valid is high and stall is low
// pipeline from input acceptance to the output register:
//   cofactor/determinant stages (products, cofactors, split det products, sum),
//   then magnitude/sign, the restoring division stages, and round/saturate
// throughput: one item per cycle unless stalled; the nine division lanes are
//   fully pipelined, one quotient bit per stage, side by side on the nine cofactors
// a zero determinant gives singular = 1 and all elements zero
// stall: when the output register holds an item and out_stall is high the
//   whole pipeline freezes and in_stall is raised; otherwise the output
//   register refills in the same cycle it is emptied
// reset (rst, synchronous) clears all valid bits; data registers are not reset
module matrix3_inverse import mi3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [EL_W-1:0] a_c0r0,
  input  logic signed [EL_W-1:0] a_c0r1,
  input  logic signed [EL_W-1:0] a_c0r2,
  input  logic signed [EL_W-1:0] a_c1r0,
  input  logic signed [EL_W-1:0] a_c1r1,
  input  logic signed [EL_W-1:0] a_c1r2,
  input  logic signed [EL_W-1:0] a_c2r0,
  input  logic signed [EL_W-1:0] a_c2r1,
  input  logic signed [EL_W-1:0] a_c2r2,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [EL_W-1:0] inv_c0r0,
  output logic signed [EL_W-1:0] inv_c0r1,
  output logic signed [EL_W-1:0] inv_c0r2,
  output logic signed [EL_W-1:0] inv_c1r0,
  output logic signed [EL_W-1:0] inv_c1r1,
  output logic signed [EL_W-1:0] inv_c1r2,
  output logic signed [EL_W-1:0] inv_c2r0,
  output logic signed [EL_W-1:0] inv_c2r1,
  output logic signed [EL_W-1:0] inv_c2r2,
  output logic                   singular
);

  // valid bits for every stage ahead of the output register
  localparam int PIPE_D = 5 + STEPS;

  logic                    adv;
  logic [PIPE_D-1:0]       vld;
  logic signed [EL_W-1:0]  a   [N_EL];
  logic signed [COF_W-1:0] cof [N_EL];
  logic signed [DET_W-1:0] det;
  logic [DET_W-1:0]        den_step [STEPS];
  logic [DET_W-1:0]        den_last;
  logic [STEPS:0]          zero;
  lane_res_t               lane_res [N_EL];
  logic [EL_W-1:0]         inv      [N_EL];
  logic [EL_W-1:0]         inv_next [N_EL];

  // pipeline moves unless a finished item sits stalled at the output
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  assign a[0] = a_c0r0;
  assign a[1] = a_c0r1;
  assign a[2] = a_c0r2;
  assign a[3] = a_c1r0;
  assign a[4] = a_c1r1;
  assign a[5] = a_c1r2;
  assign a[6] = a_c2r0;
  assign a[7] = a_c2r1;
  assign a[8] = a_c2r2;

  mi3_cofactor u_cof (
    .clk (clk),
    .adv (adv),
    .a   (a),
    .cof (cof),
    .det (det)
  );

  // determinant magnitude and zero flag travel beside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      den_step[0] <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
      zero[0]     <= (det == '0);
      for (int s = 1; s < STEPS; s++) begin
        den_step[s] <= den_step[s-1];
      end
      den_last      <= den_step[STEPS-1];
      zero[STEPS:1] <= zero[STEPS-1:0];
    end
  end

  for (genvar e = 0; e < N_EL; e++) begin : g_lane
    mi3_div_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .cof     (cof[e]),
      .det_neg (det[DET_W-1]),
      .den     (den_step),
      .res     (lane_res[e])
    );
  end

  // merge: round each lane, force zeros when singular
  always_comb begin
    for (int e = 0; e < N_EL; e++) begin
      inv_next[e] = zero[STEPS] ? '0 :
                    round_sat(lane_res[e].rem, den_last, lane_res[e].quo, lane_res[e].neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[PIPE_D-2:0], in_valid};
      out_valid <= vld[PIPE_D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < N_EL; e++) begin
        inv[e] <= inv_next[e];
      end
      singular <= zero[STEPS];
    end
  end

  assign inv_c0r0 = inv[0];
  assign inv_c0r1 = inv[1];
  assign inv_c0r2 = inv[2];
  assign inv_c1r0 = inv[3];
  assign inv_c1r1 = inv[4];
  assign inv_c1r2 = inv[5];
  assign inv_c2r0 = inv[6];
  assign inv_c2r1 = inv[7];
  assign inv_c2r2 = inv[8];

endmodule

// ===== hdl/mi3_cofactor.sv =====
module mi3_cofactor import mi3_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [EL_W-1:0]  a   [N_EL],
  output logic signed [COF_W-1:0] cof [N_EL],
  output logic signed [DET_W-1:0] det
);

  logic signed [PROD_W-1:0] pp   [N_EL];
  logic signed [PROD_W-1:0] pn   [N_EL];
  logic signed [EL_W-1:0]   e1   [N_DET];
  logic signed [COF_W-1:0]  cof2 [N_EL];
  logic signed [EL_W-1:0]   e2   [N_DET];
  logic signed [COF_W-1:0]  cof3 [N_EL];
  logic signed [COF_W-1:0]  plo  [N_DET];
  logic signed [COF_W-1:0]  phi  [N_DET];
  logic signed [DET_W-1:0]  det_next;

  // split 32x65 products into two narrow halves
  always_comb begin
    det_next = '0;
    for (int k = 0; k < N_DET; k++) begin
      det_next = det_next + (DET_W'(phi[k]) <<< EL_W) + DET_W'(plo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < N_EL; c++) begin
        pp[c]   <= a[CP_A[c]] * a[CP_B[c]];
        pn[c]   <= a[CN_A[c]] * a[CN_B[c]];
        cof2[c] <= COF_W'(pp[c]) - COF_W'(pn[c]);
        cof3[c] <= cof2[c];
        cof[c]  <= cof3[c];
      end
      for (int k = 0; k < N_DET; k++) begin
        e1[k]  <= a[DET_EL[k]];
        e2[k]  <= e1[k];
        plo[k] <= e2[k] * $signed({1'b0, cof2[k][EL_W-1:0]});
        phi[k] <= e2[k] * $signed(cof2[k][COF_W-1:EL_W]);
      end
      det <= det_next;
    end
  end

endmodule

// ===== hdl/mi3_div_lane.sv =====
module mi3_div_lane import mi3_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [COF_W-1:0] cof,
  input  logic                    det_neg,
  input  logic [DET_W-1:0]        den [STEPS],
  output lane_res_t               res
);

  logic [REM_W-1:0] rem [STEPS+1];
  logic [Q_W-1:0]   quo [STEPS+1];
  logic             neg [STEPS+1];
  logic [COF_W-1:0] cof_mag;
  logic [CMP_W-1:0] rx  [STEPS];
  logic [CMP_W-1:0] dx  [STEPS];
  logic             ge  [STEPS];

  assign cof_mag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);

  // one quotient bit per stage, msb first
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      rx[i] = CMP_W'(rem[i]);
      dx[i] = CMP_W'(den[i]) << (STEPS - 1 - i);
      ge[i] = (rx[i] >= dx[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= REM_W'(cof_mag) << (2 * FRAC_BITS);
      quo[0] <= '0;
      neg[0] <= cof[COF_W-1] ^ det_neg;
      for (int i = 0; i < STEPS; i++) begin
        rem[i+1] <= ge[i] ? REM_W'(rx[i] - dx[i]) : rem[i];
        quo[i+1] <= {quo[i][Q_W-2:0], ge[i]};
        neg[i+1] <= neg[i];
      end
    end
  end

  assign res = '{rem: rem[STEPS], quo: quo[STEPS], neg: neg[STEPS]};

endmodule
